[hdl/pcie_root_interrupt_fifo_regs_core_macros.svh]
// Assertion macros for the PCIe root port interrupt register block.
// Used by pcie_root_interrupt_fifo_regs_core; expects clk and rst_n in scope.
`ifndef PCIE_ROOT_INTERRUPT_FIFO_REGS_CORE_MACROS_SVH
`define PCIE_ROOT_INTERRUPT_FIFO_REGS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pri_pkg.sv]
// Package for the PCIe root port interrupt register block.
// Holds request and result types, register addresses, bit positions and codes.
// No dependencies.
package pri_pkg;

  localparam int PRI_FIFO_DEPTH = 16;

  // Action codes of an input request.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_EVENT = 2'd2;

  // Register byte addresses.
  localparam logic [11:0] ADDR_DECODE = 12'h138;
  localparam logic [11:0] ADDR_MASK   = 12'h13c;
  localparam logic [11:0] ADDR_PHY    = 12'h144;
  localparam logic [11:0] ADDR_PORT   = 12'h148;
  localparam logic [11:0] ADDR_FIFO1  = 12'h158;
  localparam logic [11:0] ADDR_FIFO2  = 12'h15c;

  // Bit positions inside the 32-bit registers.
  localparam int BIT_BRIDGE_EN = 0;
  localparam int BIT_LINK_UP   = 11;
  localparam int BIT_INTX      = 16;
  localparam int BIT_NOT_EMPTY = 18;
  localparam int BIT_OVERFLOW  = 19;
  localparam int LANE_POS      = 27;
  localparam int LEVEL_POS     = 29;
  localparam int VALID_POS     = 31;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] reg_addr;
    logic [31:0] write_data;
    logic [1:0]  irq_lane;
    logic        irq_level;
  } pri_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        bridge_enable;
    logic        unmapped;
  } pri_out_t;

  // One FIFO entry: the level above the lane.
  typedef struct packed {
    logic       level;
    logic [1:0] lane;
  } pri_entry_t;

endpackage

[hdl/pcie_root_interrupt_fifo_regs_core.sv]
// Interrupt register block of a PCIe root port: decode/mask words, port status
// and a ring FIFO of legacy interrupt events. Depends on pri_pkg and on
// pcie_root_interrupt_fifo_regs_core_macros.svh.
//
//   channel   handshake               payload
//   input     start, busy             in_req  (pri_in_t)
//   result    out_strobe              out_rsp (pri_out_t)
//   config    cfg_valid, cfg_ready    cfg_data (link_up)
//
// One request is taken in every cycle; its result is on out_rsp for exactly
// one cycle, the cycle after the request was taken, marked by out_strobe.
// All work of a request is one pass of logic from the current state to the
// next state and the result register, so busy is always low.
// The receiver cannot stall the result, and cfg_ready is always high.
// Reset is synchronous and active low; it clears all control state and sets
// link_up. The FIFO storage needs no clearing pass, so the block takes
// requests from the first cycle after reset.

`include "pcie_root_interrupt_fifo_regs_core_macros.svh"

module pcie_root_interrupt_fifo_regs_core
  import pri_pkg::*;
#(
  parameter int FIFO_DEPTH = PRI_FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pri_in_t  in_req,
  output logic     out_strobe,
  output pri_out_t out_rsp,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // Architectural state. Of the port status word only bridge enable, not-empty
  // and overflow can ever be set, so those three bits are all that is kept.
  logic [31:0]      status_r, status_nxt;
  logic [31:0]      mask_r, mask_nxt;
  logic             bridge_en_r, bridge_en_nxt;
  logic             not_empty_r, not_empty_nxt;
  logic             overflow_r, overflow_nxt;
  logic             irq_r, irq_nxt;
  logic             link_up_r;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;

  // FIFO storage and a registered copy of the head entry. The head copy is
  // read from the memory at the next read pointer, with a bypass for an
  // entry written in the same cycle at that place.
  pri_entry_t       fifo_mem [FIFO_DEPTH];
  pri_entry_t       head_r;
  pri_entry_t       push_entry;
  logic             push;

  // Result register.
  logic             strobe_r;
  pri_out_t         rsp_r, rsp_nxt;

  logic             accept;
  logic             nonempty;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic             recompute;

  // Terms used by the checks below.
  logic             event_taken;
  logic             intx_hold;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign nonempty  = (rd_ptr_r != wr_ptr_r);

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  assign push_entry.level = in_req.irq_level;
  assign push_entry.lane  = in_req.irq_lane;

  assign event_taken = accept && (in_req.action == ACT_EVENT);
  assign intx_hold   = recompute && (nonempty || push);

  always_comb begin
    status_nxt    = status_r;
    mask_nxt      = mask_r;
    bridge_en_nxt = bridge_en_r;
    not_empty_nxt = not_empty_r;
    overflow_nxt  = overflow_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    push          = 1'b0;
    recompute     = 1'b0;
    rsp_nxt       = '0;

    if (accept) begin
      case (in_req.action)
        ACT_READ: begin
          case (in_req.reg_addr)
            ADDR_DECODE: rsp_nxt.read_data = status_r;
            ADDR_MASK:   rsp_nxt.read_data = mask_r;
            ADDR_PHY:    rsp_nxt.read_data[BIT_LINK_UP] = link_up_r;
            ADDR_PORT: begin
              // Reading port status refreshes the not-empty bit first.
              not_empty_nxt = nonempty;
              rsp_nxt.read_data[BIT_BRIDGE_EN] = bridge_en_r;
              rsp_nxt.read_data[BIT_NOT_EMPTY] = nonempty;
              rsp_nxt.read_data[BIT_OVERFLOW]  = overflow_r;
            end
            ADDR_FIFO1: begin
              if (nonempty) begin
                rsp_nxt.read_data[VALID_POS] = 1'b1;
                rsp_nxt.read_data[LEVEL_POS] = head_r.level;
                rsp_nxt.read_data[LANE_POS +: 2] = head_r.lane;
              end
            end
            ADDR_FIFO2:  rsp_nxt.read_data = '0;
            default:     rsp_nxt.unmapped = 1'b1;
          endcase
        end
        ACT_WRITE: begin
          case (in_req.reg_addr)
            ADDR_DECODE: begin
              status_nxt = status_r & ~in_req.write_data;
              recompute  = 1'b1;
            end
            ADDR_MASK: begin
              mask_nxt  = in_req.write_data;
              recompute = 1'b1;
            end
            ADDR_PORT:   bridge_en_nxt = in_req.write_data[BIT_BRIDGE_EN];
            ADDR_FIFO1, ADDR_FIFO2: begin
              if (nonempty) begin
                rd_ptr_nxt = rd_ptr_inc;
              end
            end
            default:     rsp_nxt.unmapped = 1'b1;
          endcase
        end
        ACT_EVENT: begin
          if (wr_ptr_inc == rd_ptr_r) begin
            // Ring full: the event is dropped and the line is left alone.
            overflow_nxt = 1'b1;
          end else begin
            push       = 1'b1;
            wr_ptr_nxt = wr_ptr_inc;
            recompute  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // The INTx decode bit is forced while the FIFO holds an entry. Only a
    // pop changes emptiness without a recompute, and a decode or mask write
    // or a push never empties the FIFO.
    if (recompute && (nonempty || push)) begin
      status_nxt[BIT_INTX] = 1'b1;
    end
    irq_nxt = recompute ? (|(status_nxt & mask_nxt)) : irq_r;

    rsp_nxt.irq_out       = irq_nxt;
    rsp_nxt.bridge_enable = bridge_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      mask_r      <= '0;
      bridge_en_r <= 1'b0;
      not_empty_r <= 1'b0;
      overflow_r  <= 1'b0;
      irq_r       <= 1'b0;
      link_up_r   <= 1'b1;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      strobe_r    <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      mask_r      <= mask_nxt;
      bridge_en_r <= bridge_en_nxt;
      not_empty_r <= not_empty_nxt;
      overflow_r  <= overflow_nxt;
      irq_r       <= irq_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      strobe_r    <= accept;
      if (cfg_valid && cfg_ready) begin
        link_up_r <= cfg_data;
      end
    end
  end

  // FIFO memory and head register; payload only, no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_entry;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_entry;
    end else begin
      head_r <= fifo_mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_rsp    = rsp_r;

  // Every taken request yields exactly one result in the next cycle.
  `PRI_ASSERT_NEXT(a_result_follows, accept, out_strobe, "result missing after request")
  `PRI_ASSERT_NEXT(a_no_spurious, !accept, !out_strobe, "result without request")
  // Overflow can only rise on an interrupt event.
  `PRI_ASSERT_NEXT(a_overflow_cause, !overflow_r && !event_taken, !overflow_r, "stray overflow")
  // After a recompute the line matches decode AND mask.
  `PRI_ASSERT_NEXT(a_irq_match, recompute, irq_r == (|(status_r & mask_r)), "irq line mismatch")
  // A pending FIFO entry after a recompute always shows in the INTx bit.
  `PRI_ASSERT_SAME(a_intx_forced, intx_hold, status_nxt[BIT_INTX], "INTx not forced")

endmodule
